>>> hw/rtl/impedance_gain_phase_calibration_top_assert.svh
// Assertion macros for the calibration block checker
`ifndef IMPEDANCE_GAIN_PHASE_CALIBRATION_TOP_ASSERT_SVH
`define IMPEDANCE_GAIN_PHASE_CALIBRATION_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define IGP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define IGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/igp_pkg.sv
// Shared constants and tables for the impedance gain/phase calibration block
`timescale 1ns / 1ps
`default_nettype none

package igp_pkg;

    // CORDIC iteration count for the phase path
    localparam int CORDIC_STEPS = 20;

    localparam int XY_W = 38;
    localparam int Z_W  = 35;

    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = 31;

    // square, root, multiply, three normalize, divide setup, divide
    localparam int GAIN_LAT = 1 + SQ_STAGES + 1 + 3 + 1 + DIV_STAGES;
    // pre-rotation, CORDIC, five scaling stages
    localparam int PH_LAT   = 1 + CORDIC_STEPS + 5;
    localparam int PH_DLY   = GAIN_LAT - PH_LAT;

    localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

    // phase scaling: round(|z| * 23040000 / (6283 * 2^30))
    localparam logic [24:0] PH_SCALE = 25'd23040000;
    localparam logic [59:0] PH_HALF  = 60'd6283 << 29;
    localparam logic [12:0] PH_DIV   = 13'd6283;
    localparam logic [27:0] PH_RECIP = 28'((64'd1 << 40) / 64'd6283);

    localparam logic [31:0]        GAIN_MANT_MAX = 32'hFFFF_FFFF;
    localparam logic signed [6:0]  GAIN_EXP_MAX  = 7'sd1;
    localparam logic [23:0]        REF_OHMS_RST  = 24'd1000;

    // Q30 arctangent of 2^-i, truncated for i below 27
    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 35'sd843314856;
            1:       v = 35'sd497837829;
            2:       v = 35'sd263043836;
            3:       v = 35'sd133525158;
            4:       v = 35'sd67021686;
            5:       v = 35'sd33543515;
            6:       v = 35'sd16775850;
            7:       v = 35'sd8388437;
            8:       v = 35'sd4194282;
            9:       v = 35'sd2097149;
            10:      v = 35'sd1048575;
            11:      v = 35'sd524287;
            12:      v = 35'sd262143;
            13:      v = 35'sd131071;
            14:      v = 35'sd65535;
            15:      v = 35'sd32767;
            16:      v = 35'sd16383;
            17:      v = 35'sd8191;
            18:      v = 35'sd4095;
            19:      v = 35'sd2047;
            20:      v = 35'sd1023;
            21:      v = 35'sd511;
            22:      v = 35'sd255;
            23:      v = 35'sd127;
            24:      v = 35'sd63;
            25:      v = 35'sd31;
            26:      v = 35'sd15;
            27:      v = 35'sd8;
            28:      v = 35'sd4;
            29:      v = 35'sd2;
            30:      v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/igp_if.sv
// Stream and configuration channel interfaces of the calibration block
`timescale 1ns / 1ps
`default_nettype none

interface igp_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
    logic               last_point;
    modport source (output valid, real_part, imag_part, last_point, input ready);
    modport sink   (input valid, real_part, imag_part, last_point, output ready);
endinterface

interface igp_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        gain_mantissa;
    logic signed [6:0]  gain_exponent;
    logic signed [14:0] phase_degrees;
    logic               zero_magnitude;
    logic               last_out;
    modport source (output valid, gain_mantissa, gain_exponent, phase_degrees,
                    zero_magnitude, last_out, input ready);
    modport sink   (input valid, gain_mantissa, gain_exponent, phase_degrees,
                    zero_magnitude, last_out, output ready);
endinterface

interface igp_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] reference_ohms;
    modport source (output valid, reference_ohms, input ready);
    modport sink   (input valid, reference_ohms, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/igp_gain.sv
// Gain path: magnitude square root, reference multiply, normalize, reciprocal
`timescale 1ns / 1ps
`default_nettype none

module igp_gain (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] real_part,
    input  logic signed [15:0] imag_part,
    input  logic [23:0]        reference_ohms,
    output logic [31:0]        gain_mantissa,
    output logic signed [6:0]  gain_exponent
);
    import igp_pkg::*;

    logic signed [31:0] re_sq;
    logic signed [31:0] im_sq;
    logic [31:0]        s_reg;

    logic [33:0] rt_rem_reg  [SQ_STAGES];
    logic [31:0] rt_root_reg [SQ_STAGES];
    logic [31:0] rt_v_reg    [SQ_STAGES];

    logic [55:0] d_reg;

    logic [55:0] a1, a2, b1, b2, c1, c2;
    logic        n5, n4, n3, n2, n1, n0;
    logic [55:0] nrm1_reg, nrm2_reg, nrm3_reg;
    logic [1:0]  sh1_reg;
    logic [3:0]  sh2_reg;
    logic [5:0]  sh3_reg;

    logic [56:0]       rem0;
    logic [55:0]       dv_reg   [DIV_STAGES+1];
    logic [55:0]       rem_reg  [DIV_STAGES+1];
    logic [31:0]       q_reg    [DIV_STAGES+1];
    logic              pow2_reg [DIV_STAGES+1];
    logic              dz_reg   [DIV_STAGES+1];
    logic signed [6:0] exp_reg  [DIV_STAGES+1];

    // Sum the squares of both components
    assign re_sq = real_part * real_part;
    assign im_sq = imag_part * imag_part;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= $unsigned(re_sq) + $unsigned(im_sq);
        end
    end

    // Take sqrt(S * 2^32), one root bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        logic [33:0] rem_p;
        logic [31:0] root_p;
        logic [31:0] v_p;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic [35:0] diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign v_p    = s_reg;
        end else begin : g_next
            assign rem_p  = rt_rem_reg[k-1];
            assign root_p = rt_root_reg[k-1];
            assign v_p    = rt_v_reg[k-1];
        end

        assign rem_sh = {rem_p, v_p[31:30]};
        assign trial  = {2'b00, root_p, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign diff   = rem_sh - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_rem_reg[k]  <= ge ? diff[33:0] : rem_sh[33:0];
                rt_root_reg[k] <= {root_p[30:0], ge};
                rt_v_reg[k]    <= {v_p[29:0], 2'b00};
            end
        end
    end

    // Scale the magnitude by the reference resistance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= 56'(reference_ohms) * 56'(rt_root_reg[SQ_STAGES-1]);
        end
    end

    // Normalize the product so its top bit lands on bit 55
    always_comb
    begin
        n5 = (d_reg[55:24] == '0);
        a1 = n5 ? (d_reg << 32) : d_reg;
        n4 = (a1[55:40] == '0);
        a2 = n4 ? (a1 << 16) : a1;
        n3 = (nrm1_reg[55:48] == '0);
        b1 = n3 ? (nrm1_reg << 8) : nrm1_reg;
        n2 = (b1[55:52] == '0);
        b2 = n2 ? (b1 << 4) : b1;
        n1 = (nrm2_reg[55:54] == '0);
        c1 = n1 ? (nrm2_reg << 2) : nrm2_reg;
        n0 = !c1[55];
        c2 = n0 ? (c1 << 1) : c1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm1_reg <= a2;
            sh1_reg  <= {n5, n4};
            nrm2_reg <= b2;
            sh2_reg  <= {sh1_reg, n3, n2};
            nrm3_reg <= c2;
            sh3_reg  <= {sh2_reg, n1, n0};
        end
    end

    // Set up the reciprocal: first quotient bit is always one
    assign rem0 = (57'd1 << 56) - {1'b0, nrm3_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0]   <= nrm3_reg;
            rem_reg[0]  <= rem0[55:0];
            q_reg[0]    <= 32'd1;
            pow2_reg[0] <= (nrm3_reg == {1'b1, 55'b0});
            dz_reg[0]   <= !nrm3_reg[55];
            exp_reg[0]  <= (nrm3_reg == {1'b1, 55'b0}) ? 7'(sh3_reg) - 7'sd38
                                                        : 7'(sh3_reg) - 7'sd39;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        logic [56:0] rem_sh;
        logic [56:0] diff;
        logic        ge;

        assign rem_sh = {rem_reg[k-1], 1'b0};
        assign ge     = (rem_sh >= {1'b0, dv_reg[k-1]});
        assign diff   = rem_sh - {1'b0, dv_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k]   <= dv_reg[k-1];
                rem_reg[k]  <= ge ? diff[55:0] : rem_sh[55:0];
                q_reg[k]    <= {q_reg[k-1][30:0], ge};
                pow2_reg[k] <= pow2_reg[k-1];
                dz_reg[k]   <= dz_reg[k-1];
                exp_reg[k]  <= exp_reg[k-1];
            end
        end
    end

    // Pick saturation, exact power of two, or the quotient
    always_comb
    begin
        if (dz_reg[DIV_STAGES])
        begin
            gain_mantissa = GAIN_MANT_MAX;
            gain_exponent = GAIN_EXP_MAX;
        end
        else if (pow2_reg[DIV_STAGES])
        begin
            gain_mantissa = 32'h8000_0000;
            gain_exponent = exp_reg[DIV_STAGES];
        end
        else
        begin
            gain_mantissa = q_reg[DIV_STAGES];
            gain_exponent = exp_reg[DIV_STAGES];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/igp_phase.sv
// Phase path: vectoring CORDIC and scaling to 1/64 degree
`timescale 1ns / 1ps
`default_nettype none

module igp_phase (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] real_part,
    input  logic signed [15:0] imag_part,
    output logic signed [14:0] phase_degrees
);
    import igp_pkg::*;

    logic signed [XY_W-1:0] x0, y0;
    logic signed [XY_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cz_reg [CORDIC_STEPS+1];

    logic signed [Z_W-1:0] zf;
    logic [33:0]           mag;
    logic [59:0]           num_reg;
    logic [59:0]           num_rnd;
    logic [29:0]           t_reg;
    logic [29:0]           t3_reg;
    logic [57:0]           p_reg;
    logic [17:0]           q0;
    logic [29:0]           r_full;
    logic [17:0]           q0_reg;
    logic [14:0]           r_reg;
    logic [17:0]           q_fix;
    logic                  neg1_reg, neg2_reg, neg3_reg, neg4_reg;

    // Pre-rotate into the right half plane
    assign x0 = {{(XY_W-36){real_part[15]}}, real_part, 20'b0};
    assign y0 = {{(XY_W-36){imag_part[15]}}, imag_part, 20'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (real_part < 0)
            begin
                cx_reg[0] <= -x0;
                cy_reg[0] <= -y0;
                cz_reg[0] <= (imag_part >= 0) ? PI_Q30 : -PI_Q30;
            end
            else
            begin
                cx_reg[0] <= x0;
                cy_reg[0] <= y0;
                cz_reg[0] <= '0;
            end
        end
    end

    // Rotate toward the x axis, one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [XY_W-1:0] xs, ys;

        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cy_reg[i][XY_W-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + atan_q30(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - atan_q30(i);
                end
            end
        end
    end

    // Scale the angle magnitude, divide by 6283 * 2^30 with rounding
    assign zf      = cz_reg[CORDIC_STEPS];
    assign mag     = zf[Z_W-1] ? 34'(-zf) : 34'(zf);
    assign num_rnd = num_reg + PH_HALF;
    assign q0      = p_reg[57:40];
    assign r_full  = t3_reg - 30'(q0) * 30'(PH_DIV);
    assign q_fix   = (r_reg >= 15'(PH_DIV)) ? q0_reg + 18'd1 : q0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg       <= 60'(mag) * 60'(PH_SCALE);
            neg1_reg      <= zf[Z_W-1];
            t_reg         <= num_rnd[59:30];
            neg2_reg      <= neg1_reg;
            p_reg         <= 58'(t_reg) * 58'(PH_RECIP);
            t3_reg        <= t_reg;
            neg3_reg      <= neg2_reg;
            q0_reg        <= q0;
            r_reg         <= r_full[14:0];
            neg4_reg      <= neg3_reg;
            phase_degrees <= neg4_reg ? -(15'(q_fix)) : 15'(q_fix);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/impedance_gain_phase_calibration_top.sv
// Impedance calibration: gain factor and phase for each sweep point.
//
// Channels: sample carries one signed real/imaginary point and its last
// mark; result carries the gain (normalized mantissa and power-of-two
// exponent), the phase in 1/64 degree, a zero-magnitude flag and the last
// mark; cfg writes the 24-bit reference resistance (reset value 1000).
// cfg is always ready; write it only while no beat is in flight.
// The gain path, with its 32-stage square root and 32-stage reciprocal,
// sets when the result beat appears; the phase path (pre-rotation, CORDIC,
// five scaling stages) is delayed to match.
// Throughput: one beat per cycle while result is not held. All stages advance together; a new beat
// is taken whenever the output register is empty or being drained.
// Stall: while result is held, the whole pipeline freezes and sample.ready
// drops; nothing is lost or repeated.
// Reset: clears all valid bits and restores the reference to 1000; no
// clearing pass is needed.
// A zero point gives the saturated gain code, phase zero and the flag set.
`timescale 1ns / 1ps
`default_nettype none

module impedance_gain_phase_calibration_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    igp_sample_if.sink  sample,
    igp_result_if.source result,
    igp_cfg_if.sink     cfg
);
    import igp_pkg::*;

    logic [23:0]        ref_ohms_reg;
    logic               en;
    logic               vld_reg  [GAIN_LAT];
    logic [1:0]         side_reg [GAIN_LAT];
    logic signed [14:0] ph_dly_reg [PH_DLY];
    logic signed [14:0] ph_raw;
    logic [31:0]        g_mant;
    logic signed [6:0]  g_exp;

    logic               out_valid_reg;
    logic [31:0]        mant_reg;
    logic signed [6:0]  exp_reg;
    logic signed [14:0] phase_reg;
    logic               zero_reg;
    logic               last_reg;

    // Hold the reference resistance
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_ohms_reg <= REF_OHMS_RST;
        end
        else if (cfg.valid)
        begin
            ref_ohms_reg <= cfg.reference_ohms;
        end
    end

    // Advance when the output register is free or draining
    assign en           = !out_valid_reg || result.ready;
    assign sample.ready = en;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GAIN_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= sample.valid;
            for (int i = 1; i < GAIN_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[GAIN_LAT-1];
        end
    end

    // Carry the last mark and zero flag alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {sample.last_point,
                            (sample.real_part == '0) && (sample.imag_part == '0)};
            for (int i = 1; i < GAIN_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    igp_gain u_gain (
        .clk            (clk),
        .en             (en),
        .real_part      (sample.real_part),
        .imag_part      (sample.imag_part),
        .reference_ohms (ref_ohms_reg),
        .gain_mantissa  (g_mant),
        .gain_exponent  (g_exp)
    );

    igp_phase u_phase (
        .clk           (clk),
        .en            (en),
        .real_part     (sample.real_part),
        .imag_part     (sample.imag_part),
        .phase_degrees (ph_raw)
    );

    // Delay the phase to line up with the gain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_dly_reg[0] <= ph_raw;
            for (int i = 1; i < PH_DLY; i++)
            begin
                ph_dly_reg[i] <= ph_dly_reg[i-1];
            end
        end
    end

    // Register the result beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mant_reg  <= g_mant;
            exp_reg   <= g_exp;
            phase_reg <= side_reg[GAIN_LAT-1][0] ? 15'sd0 : ph_dly_reg[PH_DLY-1];
            zero_reg  <= side_reg[GAIN_LAT-1][0];
            last_reg  <= side_reg[GAIN_LAT-1][1];
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.gain_mantissa  = mant_reg;
    assign result.gain_exponent  = exp_reg;
    assign result.phase_degrees  = phase_reg;
    assign result.zero_magnitude = zero_reg;
    assign result.last_out       = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/igp_checker.sv
// Port-level checker for the calibration block and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "impedance_gain_phase_calibration_top_assert.svh"

module igp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [31:0]        gain_mantissa,
    input wire logic signed [6:0]  gain_exponent,
    input wire logic signed [14:0] phase_degrees,
    input wire logic               zero_magnitude,
    input wire logic               last_out
);

    // Hold a stalled result beat
    `IGP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(gain_mantissa) && $stable(phase_degrees) && $stable(last_out), "stalled result changed")

    // Saturate gain and clear phase on a zero point
    `IGP_ASSERT_NOW(a_zero_sat, out_valid && zero_magnitude, gain_mantissa == 32'hFFFF_FFFF && gain_exponent == 7'sd1 && phase_degrees == 15'sd0, "zero point not saturated")

    // Keep the mantissa normalized
    `IGP_ASSERT_NOW(a_norm, out_valid && !zero_magnitude, gain_mantissa[31], "mantissa not normalized")

    // Keep phase and exponent within their ranges
    `IGP_ASSERT_NOW(a_range, out_valid, phase_degrees <= 15'sd11521 && phase_degrees >= -15'sd11521 && gain_exponent <= 7'sd1 && gain_exponent >= -7'sd48, "result out of range")

endmodule

bind impedance_gain_phase_calibration_top igp_checker u_igp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .gain_mantissa  (result.gain_mantissa),
    .gain_exponent  (result.gain_exponent),
    .phase_degrees  (result.phase_degrees),
    .zero_magnitude (result.zero_magnitude),
    .last_out       (result.last_out)
);

`default_nettype wire
